// ===== hdl/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants for the step/direction pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

    localparam int STEP_COUNT_BITS       = 32;
    localparam int HALF_PERIOD_NUMERATOR = 500000;

    localparam int COUNT_W  = 32;
    localparam int FREQ_W   = 18;
    localparam int HP_W     = 19;
    localparam int DIV_CNT_W = $clog2(HP_W);

    localparam logic [FREQ_W-1:0] FREQ_MIN   = FREQ_W'(1);
    localparam logic [FREQ_W-1:0] FREQ_MAX   = FREQ_W'(250000);
    localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(1000);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index taken from paddr[2]
    localparam logic REG_FREQ = 1'b0;
    localparam logic REG_DIR  = 1'b1;

    typedef enum logic [1:0] {
        FN_TICK  = 2'd0,
        FN_START = 2'd1,
        FN_SLEEP = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/ssp_if.sv =====
// ----------------------------------------------------------------------------
// ssp_cmd_if / ssp_res_if
// Valid/ready channels for commands and pin status results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssp_cmd_if import ssp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [COUNT_W-1:0] step_count;
    logic               sleep_on;
    logic               fault_level;

    modport source (output valid, func, step_count, sleep_on, fault_level, input ready);
    modport sink   (input valid, func, step_count, sleep_on, fault_level, output ready);
endinterface

interface ssp_res_if import ssp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               step_level;
    logic               enable_n;
    logic               sleep_n;
    logic               dir_level;
    logic [COUNT_W-1:0] steps_done;
    logic               running;
    logic               fault_flag;

    modport source (output valid, step_level, enable_n, sleep_n, dir_level, steps_done,
                    running, fault_flag, input ready);
    modport sink   (input valid, step_level, enable_n, sleep_n, dir_level, steps_done,
                    running, fault_flag, output ready);
endinterface

`default_nettype wire

// ===== hdl/stepper_step_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// stepper_step_pulse_generator
// Step/direction pulse generator for a stepper driver. Each command transfer
// is a 1 us tick, a start with a step count, or a sleep request, and yields
// one status transfer with the pin levels after that command. A tick, sleep,
// stop (count 0) or unknown command goes straight to the done state; a
// start with a nonzero count first runs the half period division (500000 /
// frequency), which runs one quotient bit per cycle of its 19-bit quotient
// on a single shared subtractor. A new command is taken while the previous
// status still waits on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_step_pulse_generator import ssp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    ssp_cmd_if.sink                 i_cmd,
    ssp_res_if.source               o_res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam logic [HP_W-1:0] HP_NUM = HP_W'(HALF_PERIOD_NUMERATOR);

    t_state                     r_state, n_state;
    logic [DIV_CNT_W-1:0]       r_cnt, n_cnt;
    logic [HP_W-1:0]            r_rem, n_rem;
    logic [HP_W-1:0]            r_quo, n_quo;
    logic                       r_fault, n_fault;
    logic [STEP_COUNT_BITS-1:0] r_target, n_target;
    logic [STEP_COUNT_BITS-1:0] r_issued, n_issued;
    logic [HP_W-1:0]            r_half, n_half;
    logic [HP_W-1:0]            r_phase, n_phase;
    logic                       r_step, n_step;
    logic                       r_run, n_run;
    logic                       r_enable, n_enable;
    logic                       r_sleep, n_sleep;
    logic                       r_dir, n_dir;
    logic [FREQ_W-1:0]          r_freq;
    logic                       r_dirsel;
    logic                       r_out_valid, n_out_valid;

    logic                       cmd_xfer;
    logic                       cfg_wr;
    logic [STEP_COUNT_BITS-1:0] cmd_count;
    logic [HP_W-1:0]            trial;
    logic [HP_W:0]              diff;
    logic                       ge;
    logic [HP_W-1:0]            quo_next;
    logic [FREQ_W-1:0]          wr_freq;

    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite & pready;
    assign wr_freq   = pwdata[FREQ_W-1:0];
    assign cmd_xfer  = i_cmd.valid & i_cmd.ready;
    assign cmd_count = i_cmd.step_count[STEP_COUNT_BITS-1:0];
    assign i_cmd.ready = (r_state == ST_IDLE);

    // shared restoring divide step
    assign trial    = {r_rem[HP_W-2:0], HP_NUM[r_cnt]};
    assign diff     = {1'b0, trial} - (HP_W+1)'(r_freq);
    assign ge       = ~diff[HP_W];
    assign quo_next = {r_quo[HP_W-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq   <= FREQ_RESET;
            r_dirsel <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FREQ: begin
                    if (wr_freq >= FREQ_MIN && wr_freq <= FREQ_MAX) begin
                        r_freq <= wr_freq;
                    end
                end
                REG_DIR:  r_dirsel <= pwdata[0];
                default:  r_dirsel <= r_dirsel;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FREQ: prdata = PDATA_W'(r_freq);
            REG_DIR:  prdata = PDATA_W'(r_dirsel);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_target    <= '0;
            r_issued    <= '0;
            r_half      <= '0;
            r_phase     <= '0;
            r_step      <= 1'b0;
            r_run       <= 1'b0;
            r_enable    <= 1'b1;
            r_sleep     <= 1'b1;
            r_dir       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_target    <= n_target;
            r_issued    <= n_issued;
            r_half      <= n_half;
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_run       <= n_run;
            r_enable    <= n_enable;
            r_sleep     <= n_sleep;
            r_dir       <= n_dir;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_fault <= n_fault;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_out_valid || o_res.ready)) begin
            o_res.step_level <= r_step;
            o_res.enable_n   <= r_enable;
            o_res.sleep_n    <= r_sleep;
            o_res.dir_level  <= r_dir;
            o_res.steps_done <= COUNT_W'(r_issued);
            o_res.running    <= r_run;
            o_res.fault_flag <= ~r_fault;
        end
    end

    assign o_res.valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_fault     = r_fault;
        n_target    = r_target;
        n_issued    = r_issued;
        n_half      = r_half;
        n_phase     = r_phase;
        n_step      = r_step;
        n_run       = r_run;
        n_enable    = r_enable;
        n_sleep     = r_sleep;
        n_dir       = r_dir;
        n_out_valid = r_out_valid & ~o_res.ready;

        unique case (r_state)
            ST_IDLE: begin
                if (cmd_xfer) begin
                    n_fault = i_cmd.fault_level;
                    n_state = ST_DONE;
                    unique case (t_func'(i_cmd.func))
                        FN_TICK: begin
                            if (r_run) begin
                                if (r_phase > HP_W'(1)) begin
                                    n_phase = r_phase - HP_W'(1);
                                end else if (r_step) begin
                                    n_step  = 1'b0;
                                    n_phase = r_half;
                                end else if (r_issued < r_target) begin
                                    n_issued = r_issued + STEP_COUNT_BITS'(1);
                                    n_step   = 1'b1;
                                    n_phase  = r_half;
                                end else begin
                                    n_run    = 1'b0;
                                    n_enable = 1'b1;
                                    n_phase  = '0;
                                end
                            end
                        end
                        FN_START: begin
                            n_run    = 1'b0;
                            n_step   = 1'b0;
                            n_enable = 1'b1;
                            n_phase  = '0;
                            if (cmd_count != '0) begin
                                n_issued = '0;
                                n_target = cmd_count;
                                n_rem    = '0;
                                n_quo    = '0;
                                n_cnt    = DIV_CNT_W'(HP_W - 1);
                                n_state  = ST_DIV;
                            end
                        end
                        FN_SLEEP: begin
                            if (i_cmd.sleep_on) begin
                                n_run    = 1'b0;
                                n_step   = 1'b0;
                                n_enable = 1'b1;
                                n_phase  = '0;
                                n_sleep  = 1'b0;
                            end else begin
                                n_sleep  = 1'b1;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                n_rem = ge ? diff[HP_W-1:0] : trial;
                n_quo = quo_next;
                n_cnt = r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    n_half   = (quo_next == '0) ? HP_W'(1) : quo_next;
                    n_dir    = r_dirsel;
                    n_enable = 1'b0;
                    n_run    = 1'b1;
                    n_phase  = HP_W'(1);
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_run_enables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> !r_enable)
        else $error("run active with driver disabled");

    a_step_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step |-> r_run)
        else $error("step pin high outside a run");

    a_issued_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_issued <= r_target))
        else $error("issued steps beyond target");

    a_half_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_half != '0))
        else $error("zero half period in a run");

    a_div_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |=> !$past(cmd_xfer))
        else $error("command taken during division");
`endif

endmodule

`default_nettype wire

// ===== tb/stepper_step_pulse_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_step_pulse_generator_tb
// Drives ticks, starts and sleep requests into the step pulse generator
// and checks each status transfer against an in-bench model of the pins.
// A short directed part covers the idle pins, a single step, every way to
// stop a run and the frequency limits. A random part follows with runs to
// completion and disturbances, under random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module stepper_step_pulse_generator_tb import ssp_pkg::*; ();

    localparam int          RANDOM_ITEMS  = 650;
    localparam int          DRAIN_CYCLES  = 40;
    localparam int unsigned FREQ_FAST_MIN = 25000;
    // not decoded by the block
    localparam logic [1:0]  FN_UNKNOWN    = 2'd3;

    typedef struct packed {
        logic               step_level;
        logic               enable_n;
        logic               sleep_n;
        logic               dir_level;
        logic [COUNT_W-1:0] steps_done;
        logic               running;
        logic               fault_flag;
    } t_pin_status;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ssp_cmd_if cmd_if ();
    ssp_res_if res_if ();

    stepper_step_pulse_generator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // pin model
    logic [FREQ_W-1:0]  m_freq;
    logic               m_dir_sel;
    logic [COUNT_W-1:0] m_target;
    logic [COUNT_W-1:0] m_issued;
    logic [HP_W-1:0]    m_half;
    logic [HP_W-1:0]    m_countdown;
    logic               m_step;
    logic               m_run;
    logic               m_enable_n;
    logic               m_sleep_n;
    logic               m_dir;

    t_pin_status status_q[$];
    int          fail_count = 0;
    bit          gaps_on;
    int unsigned cmds_counted;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void stop_motion();
        m_run       = 1'b0;
        m_step      = 1'b0;
        m_enable_n  = 1'b1;
        m_countdown = '0;
    endfunction

    function automatic t_pin_status apply_command(logic [1:0] fn, logic [COUNT_W-1:0] count,
                                                  logic slp, logic flt);
        int unsigned half;
        t_pin_status st;
        case (fn)
            FN_TICK: begin
                if (m_run) begin
                    if (m_countdown > 1) begin
                        m_countdown = m_countdown - 1'b1;
                    end else if (m_step) begin
                        m_step      = 1'b0;
                        m_countdown = m_half;
                    end else if (m_issued < m_target) begin
                        m_issued    = m_issued + 1'b1;
                        m_step      = 1'b1;
                        m_countdown = m_half;
                    end else begin
                        stop_motion();
                    end
                end
            end
            FN_START: begin
                stop_motion();
                if (count != '0) begin
                    m_issued = '0;
                    m_target = count;
                    half = HALF_PERIOD_NUMERATOR / int'(m_freq);
                    half = half & ((1 << HP_W) - 1);
                    // cannot happen at the top frequency, kept for smaller numerators
                    if (half == 0) half = 1;
                    m_half      = HP_W'(half);
                    m_dir       = m_dir_sel;
                    m_enable_n  = 1'b0;
                    m_run       = 1'b1;
                    m_countdown = HP_W'(1);
                end
            end
            FN_SLEEP: begin
                if (slp) begin
                    stop_motion();
                    m_sleep_n = 1'b0;
                end else begin
                    m_sleep_n = 1'b1;
                end
            end
            default: ;
        endcase
        st.step_level = m_step;
        st.enable_n   = m_enable_n;
        st.sleep_n    = m_sleep_n;
        st.dir_level  = m_dir;
        st.steps_done = m_issued;
        st.running    = m_run;
        st.fault_flag = !flt;
        return st;
    endfunction

    task automatic send_cmd(input logic [1:0] fn, input logic [COUNT_W-1:0] count,
                            input logic slp, input logic flt);
        while (gaps_on && $urandom_range(0, 99) < 20) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.func        <= fn;
        cmd_if.step_count  <= count;
        cmd_if.sleep_on    <= slp;
        cmd_if.fault_level <= flt;
        do @(posedge i_clk); while (!cmd_if.ready);
        if (fn != FN_UNKNOWN && !(fn == FN_TICK && !m_run)) cmds_counted++;
        status_q.push_back(apply_command(fn, count, slp, flt));
    endtask

    task automatic wait_status_drain();
        cmd_if.valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic reg_sel, input logic [PDATA_W-1:0] data);
        logic [FREQ_W-1:0] freq;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_FREQ) begin
            freq = data[FREQ_W-1:0];
            if (freq >= FREQ_MIN && freq <= FREQ_MAX) m_freq = freq;
        end else begin
            m_dir_sel = data[0];
        end
        @(posedge i_clk);
    endtask

    task automatic send_tick();
        send_cmd(FN_TICK, $urandom, 1'($urandom), 1'($urandom));
    endtask

    task automatic send_start(input logic [COUNT_W-1:0] count);
        send_cmd(FN_START, count, 1'($urandom), 1'($urandom));
    endtask

    task automatic send_sleep(input logic slp);
        send_cmd(FN_SLEEP, $urandom, slp, 1'($urandom));
    endtask

    function automatic void check_field(string name, logic [COUNT_W-1:0] want,
                                        logic [COUNT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pin_status want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (status_q.size() == 0) begin
                $error("status transfer with nothing expected");
                fail_count++;
            end else begin
                want = status_q.pop_front();
                check_field("step_level", COUNT_W'(want.step_level),
                            COUNT_W'(res_if.step_level));
                check_field("enable_n",   COUNT_W'(want.enable_n),
                            COUNT_W'(res_if.enable_n));
                check_field("sleep_n",    COUNT_W'(want.sleep_n),
                            COUNT_W'(res_if.sleep_n));
                check_field("dir_level",  COUNT_W'(want.dir_level),
                            COUNT_W'(res_if.dir_level));
                check_field("steps_done", want.steps_done, res_if.steps_done);
                check_field("running",    COUNT_W'(want.running),
                            COUNT_W'(res_if.running));
                check_field("fault_flag", COUNT_W'(want.fault_flag),
                            COUNT_W'(res_if.fault_flag));
            end
        end
        res_if.ready <= !gaps_on || ($urandom_range(0, 99) >= 20);
    end

    task automatic test_idle_status();
        send_cmd(FN_TICK, '1, 1'b1, 1'b0);
        send_cmd(FN_UNKNOWN, $urandom, 1'b1, 1'b1);
    endtask

    task automatic test_single_step_run();
        wait_status_drain();
        cfg_write(REG_FREQ, FREQ_MAX);
        cfg_write(REG_DIR, 32'd1);
        send_start(32'd1);
        repeat (6) send_tick();
    endtask

    task automatic test_stop_paths();
        send_start(32'hFFFF_FFFF);
        send_tick();
        // stop while the step pin is high
        send_start('0);
        send_start(32'd3);
        send_tick();
        send_sleep(1'b1);
        // start while asleep
        send_start(32'd2);
        send_tick();
        send_sleep(1'b0);
        // restart while the step pin is high
        send_start(32'd4);
        send_tick();
        send_tick();
        send_start('0);
    endtask

    task automatic test_freq_limits();
        wait_status_drain();
        cfg_write(REG_FREQ, 32'd1);
        cfg_write(REG_DIR, 32'd0);
        send_start(32'd5);
        send_tick();
        send_tick();
        wait_status_drain();
        // out of range, all ignored
        cfg_write(REG_FREQ, 32'd0);
        cfg_write(REG_FREQ, FREQ_MAX + 1);
        cfg_write(REG_FREQ, 32'hFFFF_FFFF);
        send_start(32'd1);
        send_tick();
        wait_status_drain();
        cfg_write(REG_FREQ, 32'hFFFC_0000 | FREQ_MAX);
        cfg_write(REG_DIR, 32'hFFFF_FFFF);
        send_start(32'd2);
        send_tick();
        send_start('0);
    endtask

    task automatic test_random_runs();
        int unsigned        seq;
        int unsigned        n_ticks;
        logic [COUNT_W-1:0] count;
        logic [PDATA_W-1:0] freq_word;
        seq = 0;
        cmds_counted = 0;
        while (cmds_counted < RANDOM_ITEMS) begin
            // every run starts from a drained pipe
            wait_status_drain();
            gaps_on = !(seq >= 3 && seq < 6);
            case ($urandom_range(0, 9))
                0: freq_word = 32'd0;
                1: freq_word = $urandom_range(FREQ_MAX + 1, (1 << FREQ_W) - 1);
                2: freq_word = ($urandom & 32'hFFFC_0000) |
                               $urandom_range(FREQ_FAST_MIN, FREQ_MAX);
                default: freq_word = $urandom_range(FREQ_FAST_MIN, FREQ_MAX);
            endcase
            cfg_write(REG_FREQ, freq_word);
            cfg_write(REG_DIR, $urandom);
            if ($urandom_range(0, 9) == 0) count = $urandom;
            else count = $urandom_range(1, 6);
            send_start(count);
            if (count > 6) n_ticks = $urandom_range(4, 40);
            else n_ticks = 2 * m_half * count + $urandom_range(1, 3);
            repeat (n_ticks) begin
                if ($urandom_range(0, 29) == 0) begin
                    case ($urandom_range(0, 4))
                        0: send_cmd(FN_UNKNOWN, $urandom, 1'($urandom), 1'($urandom));
                        1: send_sleep(1'b1);
                        2: send_sleep(1'b0);
                        3: send_start('0);
                        default: send_start($urandom_range(1, 3));
                    endcase
                end else begin
                    send_tick();
                end
            end
            if (m_run) send_start('0);
            seq++;
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cmd_if.valid       = 1'b0;
        cmd_if.func        = FN_TICK;
        cmd_if.step_count  = '0;
        cmd_if.sleep_on    = 1'b0;
        cmd_if.fault_level = 1'b1;
        gaps_on            = 1'b1;
        cmds_counted       = 0;
        m_freq             = FREQ_RESET;
        m_dir_sel          = 1'b0;
        m_target           = '0;
        m_issued           = '0;
        m_half             = '0;
        m_countdown        = '0;
        m_step             = 1'b0;
        m_run              = 1'b0;
        m_enable_n         = 1'b1;
        m_sleep_n          = 1'b1;
        m_dir              = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_status();
        test_single_step_run();
        test_stop_paths();
        test_freq_limits();
        test_random_runs();
        wait_status_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("stepper_step_pulse_generator test passed");
        end else begin
            $display("stepper_step_pulse_generator test failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("stepper_step_pulse_generator test failed");
        $finish;
    end

endmodule
